/* hw/rtl/rfv_pkg.sv */
// Shared constants, status codes and result type for the reply frame validator.
package rfv_pkg;

  localparam int unsigned MAX_FRAME_DEFAULT = 15;
  localparam logic [7:0] FRAME_START = 8'h01;
  localparam logic [7:0] FRAME_TERM = 8'h17;
  localparam logic [16:0] FRAME_OVERHEAD = 17'd7;
  localparam int unsigned LEN_W = 16;
  localparam int unsigned SUM_W = 16;
  localparam int unsigned OUT_TDATA_W = 16;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_SHORT    = 3'd1,
    ST_LENGTH   = 3'd2,
    ST_NO_TERM  = 3'd3,
    ST_CHECKSUM = 3'd4
  } status_e;

  typedef struct packed {
    logic [7:0] command_code;
    status_e    status;
    logic       frame_valid;
  } result_t;

endpackage

/* hw/rtl/rfv_checker.sv */
// Frame state registers, per-byte capture and end-of-frame judgment.
module rfv_checker #(
  parameter int unsigned MaxFrame = rfv_pkg::MAX_FRAME_DEFAULT
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             take_i,
  input  logic [7:0]       data_i,
  input  logic             last_i,
  output rfv_pkg::result_t result_o
);

  localparam int unsigned CntW = $clog2(MaxFrame + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MaxFrame);

  logic [CntW-1:0]          count_q, count_d;
  logic                     start_ok_q, start_ok_d;
  logic [7:0]               cmd_q, cmd_d;
  logic [rfv_pkg::LEN_W-1:0] len_q, len_d;
  logic [rfv_pkg::SUM_W-1:0] sum_q, sum_d;
  logic [rfv_pkg::SUM_W-1:0] csum_q, csum_d;
  logic                     term_ok_q, term_ok_d;

  logic [16:0] pos_ext;
  logic [16:0] len4;
  logic [16:0] need;
  logic        in_frame;

  assign pos_ext = 17'(count_q);
  assign len4    = {1'b0, len_q} + 17'd4;

  always_comb begin
    count_d    = count_q;
    start_ok_d = start_ok_q;
    cmd_d      = cmd_q;
    len_d      = len_q;
    sum_d      = sum_q;
    csum_d     = csum_q;
    term_ok_d  = term_ok_q;
    in_frame   = (count_q < CntMax);
    if (in_frame) begin
      count_d = count_q + CntW'(1);
      if (pos_ext == 17'd0) begin
        start_ok_d = (data_i == rfv_pkg::FRAME_START);
      end else if (pos_ext == 17'd1) begin
        cmd_d = data_i;
      end else if (pos_ext == 17'd2) begin
        len_d = {len_q[15:8], data_i};
      end else if (pos_ext == 17'd3) begin
        len_d = {data_i, len_q[7:0]};
      end
      if (pos_ext < 17'd4 || pos_ext < len4) begin
        sum_d = sum_q + {8'd0, data_i};
      end
      if (pos_ext >= 17'd4) begin
        if (pos_ext == len4) begin
          csum_d = {csum_q[15:8], data_i};
        end else if (pos_ext == len4 + 17'd1) begin
          csum_d = {data_i, csum_q[7:0]};
        end else if (pos_ext == len4 + 17'd2) begin
          term_ok_d = (data_i == rfv_pkg::FRAME_TERM);
        end
      end
    end
  end

  assign need = {1'b0, len_d} + rfv_pkg::FRAME_OVERHEAD;

  always_comb begin
    result_o = '0;
    priority if (17'(count_d) < rfv_pkg::FRAME_OVERHEAD || !start_ok_d) begin
      result_o.status = rfv_pkg::ST_SHORT;
    end else if (need > 17'(count_d) || need > 17'(MaxFrame)) begin
      result_o.status = rfv_pkg::ST_LENGTH;
    end else if (!term_ok_d) begin
      result_o.status = rfv_pkg::ST_NO_TERM;
    end else if (csum_d + sum_d != '0) begin
      result_o.status = rfv_pkg::ST_CHECKSUM;
    end else begin
      result_o.status       = rfv_pkg::ST_OK;
      result_o.frame_valid  = 1'b1;
      result_o.command_code = cmd_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      start_ok_q <= 1'b0;
      cmd_q      <= '0;
      len_q      <= '0;
      sum_q      <= '0;
      csum_q     <= '0;
      term_ok_q  <= 1'b0;
    end else if (take_i) begin
      if (last_i) begin
        count_q    <= '0;
        start_ok_q <= 1'b0;
        cmd_q      <= '0;
        len_q      <= '0;
        sum_q      <= '0;
        csum_q     <= '0;
        term_ok_q  <= 1'b0;
      end else begin
        count_q    <= count_d;
        start_ok_q <= start_ok_d;
        cmd_q      <= cmd_d;
        len_q      <= len_d;
        sum_q      <= sum_d;
        csum_q     <= csum_d;
        term_ok_q  <= term_ok_d;
      end
    end
  end

endmodule

/* hw/rtl/rfv_out_reg.sv */
// Result register driving the master-side stream.
module rfv_out_reg (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               load_i,
  input  rfv_pkg::result_t                   result_i,
  output logic                               busy_o,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [rfv_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

  localparam int unsigned ResW = $bits(rfv_pkg::result_t);

  logic             valid_q;
  rfv_pkg::result_t res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= result_i;
    end
  end

  assign busy_o        = valid_q && !m_axis_tready;
  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = {{(rfv_pkg::OUT_TDATA_W - ResW){1'b0}}, res_q};

endmodule

/* hw/rtl/reply_frame_validator.sv */
// Top level of the reply frame validator: input register, checker and result register.
//
// Bytes of a reply buffer enter on the slave-side stream, one per request;
// s_axis_tlast marks the final byte of the buffer. On that byte the block
// judges the frame (start 0x01, command, 16-bit length, payload, 16-bit
// checksum, terminator 0x17) and sends one result on the master-side stream;
// other bytes give no result. After the last byte all frame state clears.
// Bytes beyond MaxFrame positions are counted out and ignored.
// A byte accepted into the input register is judged there by the checker, and the
// result of a last byte is registered in the result register and shown on m_axis.
// Throughput: one byte per cycle, set by the state update between the input
// register and the result register, while no last byte waits on a stalled result.
// Reset empties the input and result registers and clears all frame state.
// When the receiver stalls, the result holds; further non-last bytes keep
// flowing, and a last byte waits in the input register until the result is taken.
module reply_frame_validator #(
  parameter int unsigned MaxFrame = rfv_pkg::MAX_FRAME_DEFAULT
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [7:0]                      s_axis_tdata,  // [7:0] data_byte
  input  logic                            s_axis_tlast,  // last_byte
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [0] frame_valid, [3:1] status, [11:4] command_code, [15:12] zero
  output logic [rfv_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  logic             in_valid_q;
  logic [7:0]       in_data_q;
  logic             in_last_q;
  logic             fire;
  logic             out_busy;
  rfv_pkg::result_t result;

  assign fire          = in_valid_q && !(in_last_q && out_busy);
  assign s_axis_tready = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_data_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  rfv_checker #(
    .MaxFrame(MaxFrame)
  ) u_checker (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .take_i  (fire),
    .data_i  (in_data_q),
    .last_i  (in_last_q),
    .result_o(result)
  );

  rfv_out_reg u_out_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (fire && in_last_q),
    .result_i     (result),
    .busy_o       (out_busy),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  a_valid_means_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[0] == (m_axis_tdata[3:1] == rfv_pkg::ST_OK)))
    else $error("frame_valid disagrees with status");

  a_cmd_zero_on_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tdata[0]) |-> (m_axis_tdata[11:4] == 8'd0))
    else $error("command code not cleared on failed frame");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[3:1] <= rfv_pkg::ST_CHECKSUM))
    else $error("status code out of range");

  a_last_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && in_last_q) |=> m_axis_tvalid)
    else $error("last byte did not produce a result");

endmodule
